// ----- rtl/core/ffca_pkg.sv -----
// shared types and constants of the first-fit capacity allocator
package ffca_pkg;

	// field widths of items and results
	localparam int SLOT_W = 10;
	localparam int CAP_W = 32;

	// stream data widths, padded to whole bytes
	localparam int TDATA_W = 48;
	localparam int PAD_W = TDATA_W - SLOT_W - CAP_W;

	// item kinds carried on tuser
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_ALLOC = 1'b1;

	// one input item
	typedef struct packed {
		logic              action;
		logic [SLOT_W-1:0] bin_index;
		logic [CAP_W-1:0]  amount;
	} item_t;

	// one result item
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic [CAP_W-1:0]  remaining;
	} result_t;

endpackage

// ----- rtl/core/ffca_ram.sv -----
// generic simple dual-port ram with registered read
module ffca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/ffca_ctrl.sv -----
// sequencer for clearing, first-fit descent and max update walk over the tree memory
module ffca_ctrl #(
	parameter int BIN_COUNT = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  ffca_pkg::item_t          item,
	output logic                     res_valid,
	input  logic                     res_ready,
	output ffca_pkg::result_t        res,
	output logic                     we,
	output logic [$clog2(BIN_COUNT):0] waddr,
	output logic [ffca_pkg::CAP_W-1:0] wdata,
	output logic [$clog2(BIN_COUNT):0] raddr,
	input  logic [ffca_pkg::CAP_W-1:0] rdata
);

	localparam int LEAF_W = $clog2(BIN_COUNT);
	localparam int NODE_W = LEAF_W + 1;
	localparam int WIDE_W = LEAF_W + ffca_pkg::SLOT_W;
	localparam logic [NODE_W-1:0] ROOT = NODE_W'(1);
	localparam logic [NODE_W-1:0] SIB = NODE_W'(1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_DESC  = 3'd3;
	localparam logic [2:0] ST_LEAF  = 3'd4;
	localparam logic [2:0] ST_UP    = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]                 state_q, state_d;
	logic [NODE_W-1:0]          clr_q, clr_d;
	logic [NODE_W-1:0]          node_q, node_d;
	logic [ffca_pkg::CAP_W-1:0] val_q, val_d;
	logic [ffca_pkg::CAP_W-1:0] need_q, need_d;
	ffca_pkg::result_t          res_q, res_d;

	logic [WIDE_W-1:0]          bin_wide;
	logic [WIDE_W-1:0]          slot_wide;
	logic [NODE_W-1:0]          leaf_addr;
	logic                       bin_ok;
	logic [NODE_W-1:0]          left_child;
	logic [NODE_W-1:0]          next_node;
	logic [NODE_W-1:0]          parent;
	logic [ffca_pkg::CAP_W-1:0] up_max;
	logic [ffca_pkg::CAP_W-1:0] leaf_left;

	// bin number to leaf node and back
	assign bin_wide = WIDE_W'(item.bin_index);
	assign leaf_addr = {1'b1, bin_wide[LEAF_W-1:0]};
	assign bin_ok = 32'(item.bin_index) < 32'(BIN_COUNT);
	assign slot_wide = WIDE_W'(node_q[LEAF_W-1:0]);

	// tree navigation
	assign left_child = {node_q[NODE_W-2:0], 1'b0};
	assign next_node = (rdata >= need_q) ? left_child : (left_child | SIB);
	assign parent = node_q >> 1;
	assign up_max = (rdata > val_q) ? rdata : val_q;
	assign leaf_left = rdata - need_q;

	assign in_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res = res_q;

	// next state and memory access
	always_comb begin
		state_d = state_q;
		clr_d = clr_q;
		node_d = node_q;
		val_d = val_q;
		need_d = need_q;
		res_d = res_q;
		we = 1'b0;
		waddr = node_q;
		wdata = val_q;
		raddr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = '0;
				clr_d = clr_q + NODE_W'(1);
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (item.action == ffca_pkg::ACT_ALLOC) begin
						raddr = ROOT;
						need_d = item.amount;
						state_d = ST_CHECK;
					end else begin
						res_d.found = 1'b0;
						res_d.slot = item.bin_index;
						if (bin_ok) begin
							we = 1'b1;
							waddr = leaf_addr;
							wdata = item.amount;
							val_d = item.amount;
							node_d = leaf_addr;
							raddr = leaf_addr ^ SIB;
							res_d.remaining = item.amount;
							state_d = ST_UP;
						end else begin
							res_d.remaining = '0;
							state_d = ST_DONE;
						end
					end
				end
			end
			ST_CHECK: begin
				if (rdata < need_q) begin
					res_d = '0;
					state_d = ST_DONE;
				end else begin
					node_d = ROOT;
					raddr = {ROOT[NODE_W-2:0], 1'b0};
					state_d = ST_DESC;
				end
			end
			ST_DESC: begin
				node_d = next_node;
				if (next_node[NODE_W-1]) begin
					raddr = next_node;
					state_d = ST_LEAF;
				end else begin
					raddr = {next_node[NODE_W-2:0], 1'b0};
				end
			end
			ST_LEAF: begin
				we = 1'b1;
				waddr = node_q;
				wdata = leaf_left;
				val_d = leaf_left;
				raddr = node_q ^ SIB;
				res_d.found = 1'b1;
				res_d.slot = slot_wide[ffca_pkg::SLOT_W-1:0];
				res_d.remaining = leaf_left;
				state_d = ST_UP;
			end
			ST_UP: begin
				we = 1'b1;
				waddr = parent;
				wdata = up_max;
				val_d = up_max;
				node_d = parent;
				if (parent == ROOT) begin
					state_d = ST_DONE;
				end else begin
					raddr = parent ^ SIB;
				end
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		node_q <= node_d;
		val_q <= val_d;
		need_q <= need_d;
		res_q <= res_d;
	end

	// a node is never written and read in the same cycle outside the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(we && state_q != ST_CLEAR) |-> (waddr != raddr))
		else $error("tree write and read collide on one node");

	// the descent never sits on a leaf
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DESC) |-> !node_q[NODE_W-1])
		else $error("descent reached past the leaf level");

	// the walk up never lands on the unused node zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UP) |-> (node_q != '0))
		else $error("update walk on node zero");

	// descent only starts when the root has room for the request
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && state_d == ST_DESC) |-> (rdata >= need_q))
		else $error("descent started without a fitting bin");

endmodule

// ----- rtl/core/first_fit_capacity_allocator_unit.sv -----
// First-fit capacity allocator: free capacities of BIN_COUNT bins held in a max segment
// tree stored in one ram of 2*2^ceil(log2(BIN_COUNT)) words. After reset a clearing
// pass writes every tree node to zero, one node a cycle, and no item is taken
// meanwhile. Items then run one at a time: a request does a root check, one read per
// level on the way down, a leaf read and one sibling read per level on the way back
// up, or stops after the root check if no bin fits; a load writes its leaf and walks
// back up the tree, or writes nothing for a bin number at or above BIN_COUNT. A
// finished result sits in an output register, so the next item is taken while it waits.
module first_fit_capacity_allocator_unit #(
	parameter int BIN_COUNT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// bin_index [9:0], amount [41:10], zero [47:42]
	input  logic [47:0] s_tdata,
	// action [0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// slot [9:0], remaining [41:10], zero [47:42]
	output logic [47:0] m_tdata,
	// found [0]
	output logic        m_tuser
);

	localparam int NODE_W = $clog2(BIN_COUNT) + 1;
	localparam int DEPTH = 2 ** NODE_W;

	ffca_pkg::item_t             item;
	ffca_pkg::result_t           res;
	logic                        res_valid;
	logic                        res_ready;
	logic                        we;
	logic [NODE_W-1:0]           waddr;
	logic [NODE_W-1:0]           raddr;
	logic [ffca_pkg::CAP_W-1:0]  wdata;
	logic [ffca_pkg::CAP_W-1:0]  rdata;
	logic                        out_valid_q;
	ffca_pkg::result_t           out_q;

	// unpack the input item
	assign item.action = s_tuser;
	assign item.bin_index = s_tdata[ffca_pkg::SLOT_W-1:0];
	assign item.amount = s_tdata[ffca_pkg::SLOT_W +: ffca_pkg::CAP_W];

	ffca_ctrl #(
		.BIN_COUNT(BIN_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.item      (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.raddr     (raddr),
		.rdata     (rdata)
	);

	ffca_ram #(
		.WIDTH(ffca_pkg::CAP_W),
		.DEPTH(DEPTH)
	) u_tree (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// output register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_q.found;
	assign m_tdata = {{ffca_pkg::PAD_W{1'b0}}, out_q.remaining, out_q.slot};

endmodule
